FILE: rtl/core/wpc_pkg.sv
// Shared types, constants and helpers for the windowed peak capture block.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none

package wpc_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int MAG_W        = SAMPLE_W - 1;
    localparam int CNT_W        = 16;
    localparam int BRANCHES_MAX = 4;
    localparam int TRIPLE_LEN   = 3;

    localparam logic [CNT_W-1:0] WINDOW_RESET = 16'd25000;

    // APB register map: one 32-bit register per word
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;

    // Position of each sample inside a triple
    localparam int TRIP_SUM = 0;
    localparam int TRIP_LR  = 1;
    localparam int TRIP_BT  = 2;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef sample_t [TRIPLE_LEN-1:0] triple_t;
    typedef logic [MAG_W-1:0] mag_t;

    typedef struct packed {
        sample_t sum_a;
        sample_t lr_a;
        sample_t bt_a;
        sample_t sum_b;
        sample_t lr_b;
        sample_t bt_b;
        sample_t sum_c;
        sample_t lr_c;
        sample_t bt_c;
        sample_t sum_d;
        sample_t lr_d;
        sample_t bt_d;
    } in_beat_t;

    typedef struct packed {
        sample_t peak_value;
        logic    is_last;
    } out_beat_t;

    typedef struct packed {
        logic take;   // beat accepted this cycle
        logic flush;  // beat closes the window: clear after capture
    } lane_ctl_t;

    // |s|, with the most negative value clamped to the largest magnitude
    function automatic mag_t sat_mag(sample_t s);
        logic [SAMPLE_W-1:0] neg;
        mag_t                m;
        begin
            neg = ~s + 1'b1;
            if (!s[SAMPLE_W-1])
            begin
                m = s[MAG_W-1:0];
            end
            else if (neg[SAMPLE_W-1])
            begin
                m = '1;
            end
            else
            begin
                m = neg[MAG_W-1:0];
            end
            return m;
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/windowed_peak_capture_four_branch.sv
// Windowed peak capture over up to four branches. Takes one input beat per
// clock: each branch lane compares |sum| against its held maximum and keeps
// the (sum, lr, bt) triple of the strict maximum, all lanes in the same
// cycle. When the sample count reaches window_length the closing beat is
// folded in, the merge stage latches all triples and sends 3*BRANCHES result
// beats, one per cycle while out_stall is low, as the lanes start the next
// window at once. Input stalls only when a window closes while the previous
// report is still being sent: window_length below 3*BRANCHES or output stall.
// window_length sits at APB byte address 0 (reset 25000; 0 means 65536).
// Depends on wpc_pkg, wpc_lane and wpc_report.
`default_nettype none

module windowed_peak_capture_four_branch
    import wpc_pkg::*;
#(
    parameter int BRANCHES = BRANCHES_MAX
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_beat_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_beat_t                  out_data,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    localparam int NRES = TRIPLE_LEN * BRANCHES;

    logic [CNT_W-1:0]    window_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [REG_IDX_W-1:0] reg_index;
    logic                window_hit;
    logic                take;
    logic                report_free;
    lane_ctl_t           lane_ctl;
    triple_t             in_trip [BRANCHES_MAX];
    triple_t             cap_next [BRANCHES];
    sample_t [NRES-1:0]  load_data;

    // APB register
    assign pready    = 1'b1;
    assign reg_index = paddr[APB_ADDR_W-1:2];
    assign prdata    = (reg_index == REG_WINDOW_LENGTH) ?
                       APB_DATA_W'(window_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
        end
        else if (psel && penable && pwrite && pready &&
                 (reg_index == REG_WINDOW_LENGTH))
        begin
            window_reg <= pwdata[CNT_W-1:0];
        end
    end

    // Sample counter; wraps at 2^16 like the window compare expects
    assign count_next = count_reg + 1'b1;
    assign window_hit = (count_next == window_reg);
    assign in_stall   = window_hit && !report_free;
    assign take       = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (take)
        begin
            count_reg <= window_hit ? '0 : count_next;
        end
    end

    assign lane_ctl.take  = take;
    assign lane_ctl.flush = window_hit;

    assign in_trip[0] = {in_data.bt_a, in_data.lr_a, in_data.sum_a};
    assign in_trip[1] = {in_data.bt_b, in_data.lr_b, in_data.sum_b};
    assign in_trip[2] = {in_data.bt_c, in_data.lr_c, in_data.sum_c};
    assign in_trip[3] = {in_data.bt_d, in_data.lr_d, in_data.sum_d};

    for (genvar b = 0; b < BRANCHES; b++)
    begin : g_lane
        wpc_lane u_lane (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctl          (lane_ctl),
            .sample       (in_trip[b]),
            .capture_next (cap_next[b])
        );

        for (genvar k = 0; k < TRIPLE_LEN; k++)
        begin : g_pack
            assign load_data[TRIPLE_LEN*b + k] = cap_next[b][k];
        end
    end

    wpc_report #(
        .BRANCHES (BRANCHES)
    ) u_report (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take && window_hit),
        .load_data (load_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .free      (report_free)
    );

endmodule

`default_nettype wire

FILE: rtl/core/wpc_lane.sv
// One branch of the peak search: magnitude compare and triple capture.
// Depends on wpc_pkg.
`default_nettype none

module wpc_lane
    import wpc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire lane_ctl_t ctl,
    input  wire triple_t   sample,
    output triple_t        capture_next
);

    mag_t    best_reg;
    mag_t    best_next;
    triple_t capture_reg;
    mag_t    sample_mag;
    logic    beats_best;

    assign sample_mag = sat_mag(sample[TRIP_SUM]);
    // strict compare keeps the first of equal maxima
    assign beats_best = ctl.take && (sample_mag > best_reg);

    always_comb
    begin
        best_next    = beats_best ? sample_mag : best_reg;
        capture_next = beats_best ? sample : capture_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg    <= '0;
            capture_reg <= '0;
        end
        else if (ctl.take)
        begin
            if (ctl.flush)
            begin
                best_reg    <= '0;
                capture_reg <= '0;
            end
            else
            begin
                best_reg    <= best_next;
                capture_reg <= capture_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/wpc_report.sv
// Merge stage: latches all lane captures at window close and streams them
// out one beat per cycle while out_stall is low, last beat marked. Depends on wpc_pkg.
`default_nettype none

module wpc_report
    import wpc_pkg::*;
#(
    parameter int BRANCHES = BRANCHES_MAX
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                load,
    input  wire sample_t [TRIPLE_LEN*BRANCHES-1:0]   load_data,
    input  wire logic                                out_stall,
    output logic                                     out_valid,
    output out_beat_t                                out_data,
    output logic                                     free
);

    localparam int NRES  = TRIPLE_LEN * BRANCHES;
    localparam int IDX_W = $clog2(NRES);

    sample_t [NRES-1:0] report_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;
    logic               busy_reg;
    logic               busy_next;
    logic               last_beat;
    logic               out_take;

    assign last_beat = (idx_reg == IDX_W'(NRES - 1));
    assign out_take  = busy_reg && !out_stall;
    assign free      = !busy_reg || (out_take && last_beat);

    assign out_valid           = busy_reg;
    assign out_data.peak_value = report_reg[idx_reg];
    assign out_data.is_last    = last_beat;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (out_take)
        begin
            if (last_beat)
            begin
                busy_next = 1'b0;
                idx_next  = '0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            report_reg <= load_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/wpc_checker.sv
// Port-level checks for windowed_peak_capture_four_branch, bound to the top.
// Depends on wpc_pkg.
`default_nettype none

module wpc_checker
    import wpc_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  out_valid,
    input wire logic                  out_stall,
    input wire out_beat_t             out_data,
    input wire logic                  psel,
    input wire logic                  penable,
    input wire logic                  pwrite,
    input wire logic [APB_ADDR_W-1:0] paddr,
    input wire logic [APB_DATA_W-1:0] pwdata,
    input wire logic [APB_DATA_W-1:0] prdata,
    input wire logic                  pready
);

    // hold valid while the beat is stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("out_data changed while stalled");

    // a report streams without gaps until its last beat
    a_report_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_data.is_last |=> out_valid)
        else $error("report ended before its last beat");

    // a window_length write reads back on the next cycle
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && (paddr[APB_ADDR_W-1:2] == REG_WINDOW_LENGTH)
        |=> (paddr[APB_ADDR_W-1:2] != REG_WINDOW_LENGTH) ||
            (prdata[CNT_W-1:0] == $past(pwdata[CNT_W-1:0])))
        else $error("window_length readback mismatch");

endmodule

bind windowed_peak_capture_four_branch wpc_checker u_wpc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
);

`default_nettype wire
